// ===== rtl/flm_pkg.sv =====
`timescale 1ns / 1ps
// flm_pkg: shared types, constants and helpers of the fixed-string line matcher.
// No dependencies; every other file of the block imports it.
package flm_pkg;

    localparam int PAT_BYTES   = 32;   // bytes held by the pattern registers
    localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
    localparam int PLEN_W      = 6;    // pattern_length register width
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LINE_NUM_W  = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5A;
    localparam logic [7:0] CASE_STEP = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT0,
        REG_PAT1,
        REG_PAT2,
        REG_PAT3,
        REG_PLEN,
        REG_FOLD
    } cfg_reg_t;

    // Classified input item handed from the front to the back.
    typedef struct packed {
        logic       eos;
        logic       nl;
        logic       zero;
        logic [7:0] data;
    } item_t;

    // Current configuration as seen by the match engine.
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [PLEN_W-1:0]         length;
        logic                      fold;
    } cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= CHAR_A && b <= CHAR_Z)
        begin
            r = b + CASE_STEP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/flm_in_if.sv =====
`timescale 1ns / 1ps
// flm_in_if: text input channel (op and text byte with valid/ready).
// Depends on flm_pkg.
interface flm_in_if;
    import flm_pkg::*;

    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

// ===== rtl/flm_out_if.sv =====
`timescale 1ns / 1ps
// flm_out_if: result channel (line report or end-of-stream status).
// Depends on flm_pkg.
interface flm_out_if;
    import flm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  line_valid;
    logic [LINE_NUM_W-1:0] line_number;
    logic                  line_matched;
    logic                  stream_done;
    logic                  exit_status;

    modport source (output valid, output line_valid, output line_number, output line_matched,
                     output stream_done, output exit_status, input ready);
    modport sink   (input valid, input line_valid, input line_number, input line_matched,
                     input stream_done, input exit_status, output ready);
endinterface

// ===== rtl/flm_cfg_if.sv =====
`timescale 1ns / 1ps
// flm_cfg_if: register write channel (index and data with valid/ready).
// Depends on flm_pkg.
interface flm_cfg_if;
    import flm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/flm_front.sv =====
`timescale 1ns / 1ps
// flm_front: accepts text items and classifies them into a registered stage.
// Depends on flm_pkg and flm_in_if.
module flm_front (
    input  logic            clk,
    input  logic            rst_n,
    flm_in_if.sink          text,
    output logic            q_valid,
    input  logic            q_ready,
    output flm_pkg::item_t  q_item
);
    import flm_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign text.ready = !valid_reg || q_ready;
    assign q_valid    = valid_reg;
    assign q_item     = item_reg;

    always_comb
    begin
        item_next.eos  = (text.op == OP_END);
        item_next.nl   = (text.op == OP_BYTE) && (text.text_byte == CHAR_NL);
        item_next.zero = (text.op == OP_BYTE) && (text.text_byte == CHAR_NUL);
        item_next.data = text.text_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/flm_queue.sv =====
`timescale 1ns / 1ps
// flm_queue: short FIFO of classified items between front and back.
// Depends on flm_pkg.
module flm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  flm_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output flm_pkg::item_t  out_item
);
    import flm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/flm_back.sv =====
`timescale 1ns / 1ps
// flm_back: match engine - byte window compare, line bookkeeping, result register.
// Depends on flm_pkg and flm_out_if.
module flm_back #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_BUFFER = 512
) (
    input  logic            clk,
    input  logic            rst_n,
    input  flm_pkg::cfg_t   cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  flm_pkg::item_t  q_item,
    flm_out_if.source       result
);
    import flm_pkg::*;

    localparam int CW    = $clog2(LINE_BUFFER);
    localparam int SW    = $clog2(PATTERN_MAX + 1);
    localparam int HIST  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int CMPW  = (SW > PLEN_W) ? SW : PLEN_W;

    // aligned, folded pattern: lane k holds the byte that must sit k places back
    logic [PLEN_W-1:0]     plen_c;
    logic [7:0]            apat_c      [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] lane_en_c;
    logic [PLEN_W-1:0]     plen_reg;
    logic                  fold_reg;
    logic [7:0]            apat_reg    [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] lane_en_reg;

    logic [7:0]            hist_reg    [HIST];
    logic [CW-1:0]         chunk_reg;
    logic [SW-1:0]         search_reg;
    logic                  zero_reg;
    logic                  hit_reg;
    logic [LINE_NUM_W-1:0] lines_reg;
    logic                  any_reg;

    logic                  out_valid_reg;
    logic                  out_line_valid_reg;
    logic [LINE_NUM_W-1:0] out_number_reg;
    logic                  out_matched_reg;
    logic                  out_done_reg;
    logic                  out_exit_reg;

    logic [PATTERN_MAX-1:0] lane_ok;
    logic                  window_eq;
    logic [SW-1:0]         search_inc;
    logic                  zero_now;
    logic                  new_hit;
    logic                  line_hit;
    logic                  line_final;
    logic                  close_byte;
    logic                  have_line;
    logic                  eos_hit;
    logic [LINE_NUM_W-1:0] lines_inc;
    logic                  pop;

    // pattern_length is six bits, so lengths above PATTERN_MAX are clamped to PATTERN_MAX
    always_comb
    begin
        int idx;
        idx    = 0;
        plen_c = cfg.length;
        if (int'(cfg.length) > PATTERN_MAX)
        begin
            plen_c = PLEN_W'(PATTERN_MAX);
        end
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            idx          = int'(plen_c) - 1 - k;
            apat_c[k]    = '0;
            lane_en_c[k] = (k < int'(plen_c));
            if (idx >= 0 && idx < PAT_BYTES)
            begin
                apat_c[k] = fold_byte(cfg.pattern[idx[PAT_IDX_W-1:0]], cfg.fold);
            end
        end
    end

    always_comb
    begin
        lane_ok[0] = !lane_en_reg[0] || (fold_byte(q_item.data, fold_reg) == apat_reg[0]);
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            lane_ok[k] = !lane_en_reg[k] ||
                         (fold_byte(hist_reg[k-1], fold_reg) == apat_reg[k]);
        end
    end

    assign window_eq  = &lane_ok;
    assign search_inc = (search_reg == SW'(PATTERN_MAX)) ? search_reg : search_reg + 1'b1;
    assign zero_now   = zero_reg || q_item.zero;
    assign new_hit    = !zero_now && (plen_reg != '0) &&
                        (CMPW'(search_inc) >= CMPW'(plen_reg)) && window_eq;
    assign line_hit   = hit_reg || new_hit;
    assign line_final = line_hit || (plen_reg == '0);
    assign close_byte = q_item.nl || (chunk_reg >= CW'(LINE_BUFFER - 2));
    assign have_line  = (chunk_reg != '0);
    assign eos_hit    = have_line && (hit_reg || (plen_reg == '0));
    assign lines_inc  = (&lines_reg) ? lines_reg : lines_reg + 1'b1;

    assign q_ready = !out_valid_reg || result.ready;
    assign pop     = q_valid && q_ready;

    assign result.valid        = out_valid_reg;
    assign result.line_valid   = out_line_valid_reg;
    assign result.line_number  = out_number_reg;
    assign result.line_matched = out_matched_reg;
    assign result.stream_done  = out_done_reg;
    assign result.exit_status  = out_exit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg     <= '0;
            search_reg    <= '0;
            zero_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            lines_reg     <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && q_item.eos)
            begin
                chunk_reg     <= '0;
                search_reg    <= '0;
                zero_reg      <= 1'b0;
                hit_reg       <= 1'b0;
                lines_reg     <= '0;
                any_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (pop && close_byte)
            begin
                chunk_reg     <= '0;
                search_reg    <= '0;
                zero_reg      <= 1'b0;
                hit_reg       <= 1'b0;
                lines_reg     <= lines_inc;
                any_reg       <= any_reg || line_final;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                chunk_reg <= chunk_reg + 1'b1;
                zero_reg  <= zero_now;
                hit_reg   <= line_hit;
                if (!zero_now)
                begin
                    search_reg <= search_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plen_reg    <= plen_c;
        fold_reg    <= cfg.fold;
        apat_reg    <= apat_c;
        lane_en_reg <= lane_en_c;
        if (pop && !q_item.eos)
        begin
            hist_reg[0] <= q_item.data;
            for (int k = 1; k < HIST; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
        if (pop && q_item.eos)
        begin
            out_line_valid_reg <= have_line;
            out_number_reg     <= have_line ? lines_inc : '0;
            out_matched_reg    <= eos_hit;
            out_done_reg       <= 1'b1;
            out_exit_reg       <= !(any_reg || eos_hit);
        end
        else if (pop && close_byte)
        begin
            out_line_valid_reg <= 1'b1;
            out_number_reg     <= lines_inc;
            out_matched_reg    <= line_final;
            out_done_reg       <= 1'b0;
            out_exit_reg       <= 1'b0;
        end
    end

`ifndef SYNTH
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg <= CW'(LINE_BUFFER - 2))
        else $error("line length passed the forced line end");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.eos |=> chunk_reg == '0 && lines_reg == '0 && !any_reg)
        else $error("stream state not cleared after end of stream");

    a_zero_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        zero_reg |-> chunk_reg != '0)
        else $error("zero byte flag set on an empty line");

    a_line_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_line_valid_reg |-> out_number_reg != '0)
        else $error("line report with line number zero");
`endif

endmodule

// ===== rtl/fixed_string_line_matcher.sv =====
`timescale 1ns / 1ps
// fixed_string_line_matcher: top level - register file, front, queue and match engine.
// Depends on flm_pkg, flm_in_if, flm_out_if, flm_cfg_if, flm_front, flm_queue, flm_back.
//
// Channel   Dir  Payload                                              Transfer
// text      in   op, text_byte                                        valid & ready
// result    out  line_valid, line_number, line_matched, stream_done,  valid & ready
//                exit_status
// cfg       in   index, data                                          valid & ready
//
// One text byte per cycle sustained while results are taken; an item passes the front
// stage, the queue and the match engine with its result register on its way to a result.
// The window compare checks all PATTERN_MAX bytes at once, combinationally.
// rst_n clears stream state and the configuration registers to zero; a new stream starts at line 1.
// A stalled result holds the engine, the two-entry queue absorbs the front's
// items, then text.ready drops. cfg.ready is always high.
module fixed_string_line_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_BUFFER = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    flm_in_if.sink    text,
    flm_out_if.source result,
    flm_cfg_if.sink   cfg
);
    import flm_pkg::*;

    localparam int WORD_BYTES = CFG_DATA_W / 8;

    // pattern words as written, byte 0 of word 0 is pattern byte 0
    logic [CFG_DATA_W-1:0] pat_words_reg [PAT_BYTES / WORD_BYTES];
    logic [PLEN_W-1:0]     plen_reg;
    logic                  fold_reg;
    cfg_t                  cfg_cur;

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            cfg_cur.pattern[i] = pat_words_reg[i / WORD_BYTES][(i % WORD_BYTES) * 8 +: 8];
        end
        cfg_cur.length = plen_reg;
        cfg_cur.fold   = fold_reg;
    end

    // register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAT_BYTES / WORD_BYTES; i++)
            begin
                pat_words_reg[i] <= '0;
            end
            plen_reg <= '0;
            fold_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_PAT0: pat_words_reg[0] <= cfg.data;
                REG_PAT1: pat_words_reg[1] <= cfg.data;
                REG_PAT2: pat_words_reg[2] <= cfg.data;
                REG_PAT3: pat_words_reg[3] <= cfg.data;
                REG_PLEN: plen_reg         <= cfg.data[PLEN_W-1:0];
                REG_FOLD: fold_reg         <= cfg.data[0];
                default:  ;
            endcase
        end
    end

    // front: takes a transfer and tags it (end of stream, newline, zero byte)
    flm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    // decoupling queue so the front keeps taking bytes while a result waits, until it fills
    flm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // back: window compare, line counting, result register
    flm_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_BUFFER (LINE_BUFFER)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_cur),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_item  (qb_item),
        .result  (result)
    );

endmodule
